// ===== rtl/dsha_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared types, round constants and sha-256 round functions
// used by every module of the double sha-256 nonce checker
package dsha_pkg;

   typedef logic [31:0] word_type;
   typedef word_type [7:0] state_type;
   typedef word_type [15:0] block_type;

   localparam int RoundCount = 64;
   localparam int CsrIndexWidth = 3;
   localparam int LzWidth = 9;
   localparam int DiffWidth = 6;

   localparam logic [CsrIndexWidth-1:0] CSR_MID_01 = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_MID_23 = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_MID_45 = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_MID_67 = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_TAIL_01 = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_TAIL_2 = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_DIFF = 3'd6;

   localparam logic [DiffWidth-1:0] DIFF_RESET = 6'd1;

   localparam word_type PAD_WORD = 32'h8000_0000;
   localparam word_type INNER_LEN = 32'h0000_0280;
   localparam word_type OUTER_LEN = 32'h0000_0100;

   localparam state_type STD_IV = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   localparam word_type RK [RoundCount] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic word_type ror(input word_type x, input int n);
      ror = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sig0(input word_type x);
      big_sig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
   endfunction

   function automatic word_type big_sig1(input word_type x);
      big_sig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
   endfunction

   function automatic word_type small_sig0(input word_type x);
      small_sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sig1(input word_type x);
      small_sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
   endfunction

   // one compression round, word 0 is a
   function automatic state_type sha_round(input state_type v, input word_type kw);
      word_type t1;
      word_type t2;
      state_type r;
      t1 = v[7] + big_sig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kw;
      t2 = big_sig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      r[7] = v[6];
      r[6] = v[5];
      r[5] = v[4];
      r[4] = v[3] + t1;
      r[3] = v[2];
      r[2] = v[1];
      r[1] = v[0];
      r[0] = t1 + t2;
      sha_round = r;
   endfunction

   // slide the schedule window by one word
   function automatic block_type next_window(input block_type w);
      block_type r;
      for (int k = 0; k < 15; k++) begin
         r[k] = w[k+1];
      end
      r[15] = small_sig1(w[14]) + w[9] + small_sig0(w[1]) + w[0];
      next_window = r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/double_sha256_nonce_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// double sha-256 nonce checker: midstate compression of the header tail
// with the nonce, a second sha-256 over the digest, leading zero count
// channels: req_ (nonce in), rsp_ (count and target flag out), csr_ (config)
// a transaction moves when valid is high and stall is low at a rising edge
// csr writes complete when csr_valid and csr_ready are high; csr_ready is
// always high; write config only while no transaction is in flight
// throughput: one nonce per cycle while the pipeline is not held, every pipeline stage holds one nonce
// path from req to rsp: 64 rounds plus a final add per compression, then
// two count stages
// the whole pipeline holds while rsp_stall is high with a result waiting;
// req_stall follows it, so nothing is lost or repeated
// reset clears all valid bits and the config registers (difficulty to 1)
module double_sha256_nonce_checker
   import dsha_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [31:0]              req_nonce,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [LzWidth-1:0]            rsp_leading_zero_bits,
   output logic                          rsp_meets_target,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [63:0]              csr_data
);

   state_type          mid_ff;
   word_type           tail_ff [3];
   logic [DiffWidth-1:0] diff_ff;
   logic               en;
   block_type          blk1;
   block_type          blk2;
   logic               v1;
   state_type          dig1;
   logic               v2;
   state_type          dig2;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff  <= '0;
         tail_ff <= '{default: '0};
         diff_ff <= DIFF_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MID_01:  begin mid_ff[0] <= csr_data[63:32]; mid_ff[1] <= csr_data[31:0]; end
            CSR_MID_23:  begin mid_ff[2] <= csr_data[63:32]; mid_ff[3] <= csr_data[31:0]; end
            CSR_MID_45:  begin mid_ff[4] <= csr_data[63:32]; mid_ff[5] <= csr_data[31:0]; end
            CSR_MID_67:  begin mid_ff[6] <= csr_data[63:32]; mid_ff[7] <= csr_data[31:0]; end
            CSR_TAIL_01: begin tail_ff[0] <= csr_data[63:32]; tail_ff[1] <= csr_data[31:0]; end
            CSR_TAIL_2:  begin tail_ff[2] <= csr_data[31:0]; end
            CSR_DIFF:    begin diff_ff <= csr_data[DiffWidth-1:0]; end
            default:     begin end
         endcase
      end
   end

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   always_comb begin
      blk1     = '0;
      blk1[0]  = tail_ff[0];
      blk1[1]  = tail_ff[1];
      blk1[2]  = tail_ff[2];
      blk1[3]  = {req_nonce[7:0], req_nonce[15:8], req_nonce[23:16], req_nonce[31:24]};
      blk1[4]  = PAD_WORD;
      blk1[15] = INNER_LEN;
   end

   dsha_compress u_inner (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_valid),
      .in_block   (blk1),
      .init_state (mid_ff),
      .out_valid  (v1),
      .out_digest (dig1)
   );

   always_comb begin
      blk2 = '0;
      for (int j = 0; j < 8; j++) begin
         blk2[j] = dig1[j];
      end
      blk2[8]  = PAD_WORD;
      blk2[15] = OUTER_LEN;
   end

   dsha_compress u_outer (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (v1),
      .in_block   (blk2),
      .init_state (STD_IV),
      .out_valid  (v2),
      .out_digest (dig2)
   );

   dsha_lzc u_lzc (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (v2),
      .in_digest  (dig2),
      .difficulty (diff_ff),
      .out_valid  (rsp_valid),
      .out_count  (rsp_leading_zero_bits),
      .out_meets  (rsp_meets_target)
   );

endmodule
`default_nettype wire

// ===== rtl/dsha_compress.sv =====
`timescale 1ns / 1ps
`default_nettype none
// fully unrolled sha-256 compression, one round per register stage
// plus a final stage adding the initial state; uses dsha_pkg
module dsha_compress
   import dsha_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      en,
   input  wire logic      in_valid,
   input  wire block_type in_block,
   input  wire state_type init_state,
   output logic           out_valid,
   output state_type      out_digest
);

   state_type st_ff [1:RoundCount];
   block_type w_ff [1:RoundCount];
   logic      v_ff [1:RoundCount];
   state_type dig_ff;
   logic      dv_ff;

   for (genvar r = 0; r < RoundCount; r++) begin : g_round
      state_type st_cur;
      block_type w_cur;
      logic      v_cur;
      state_type st_in;
      block_type w_in;

      if (r == 0) begin : g_first
         assign st_cur = init_state;
         assign w_cur  = in_block;
         assign v_cur  = in_valid;
      end else begin : g_next
         assign st_cur = st_ff[r];
         assign w_cur  = w_ff[r];
         assign v_cur  = v_ff[r];
      end

      assign st_in = sha_round(st_cur, RK[r] + w_cur[0]);
      assign w_in  = next_window(w_cur);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[r+1] <= 1'b0;
         end else if (en) begin
            v_ff[r+1] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[r+1] <= st_in;
            w_ff[r+1]  <= w_in;
         end
      end
   end

   state_type dig_in;
   always_comb begin
      for (int j = 0; j < 8; j++) begin
         dig_in[j] = st_ff[RoundCount][j] + init_state[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= 1'b0;
      end else if (en) begin
         dv_ff <= v_ff[RoundCount];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dig_ff <= dig_in;
      end
   end

   assign out_valid  = dv_ff;
   assign out_digest = dig_ff;

endmodule
`default_nettype wire

// ===== rtl/dsha_lzc.sv =====
`timescale 1ns / 1ps
`default_nettype none
// leading zero count over the byte-reversed digest, two stages,
// and the difficulty compare; uses dsha_pkg
module dsha_lzc
   import dsha_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire state_type            in_digest,
   input  wire logic [DiffWidth-1:0] difficulty,
   output logic                      out_valid,
   output logic [LzWidth-1:0]        out_count,
   output logic                      out_meets
);

   logic [255:0] rev;
   logic [5:0]   grp_in [8];
   logic [5:0]   grp_ff [8];
   logic         gv_ff;
   logic [LzWidth-1:0] tot_in;
   logic [LzWidth-1:0] cnt_ff;
   logic         meets_ff;
   logic         ov_ff;

   // byte i of the reversed digest is byte (i mod 4) of word 7 - i/4
   always_comb begin
      for (int i = 0; i < 32; i++) begin
         rev[255-8*i -: 8] = in_digest[7-i/4][8*(i%4) +: 8];
      end
   end

   for (genvar g = 0; g < 8; g++) begin : g_grp
      logic [31:0] seg;
      assign seg = rev[255-32*g -: 32];
      always_comb begin
         logic found;
         found     = 1'b0;
         grp_in[g] = 6'd32;
         for (int b = 31; b >= 0; b--) begin
            if (!found && seg[b]) begin
               found     = 1'b1;
               grp_in[g] = 6'(31 - b);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         grp_ff <= grp_in;
      end
   end

   always_comb begin
      logic stop;
      stop   = 1'b0;
      tot_in = '0;
      for (int g = 0; g < 8; g++) begin
         if (!stop) begin
            tot_in = tot_in + LzWidth'(grp_ff[g]);
            stop   = (grp_ff[g] != 6'd32);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (en) begin
         gv_ff <= in_valid;
         ov_ff <= gv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cnt_ff   <= tot_in;
         meets_ff <= (tot_in >= LzWidth'(difficulty));
      end
   end

   assign out_valid = ov_ff;
   assign out_count = cnt_ff;
   assign out_meets = meets_ff;

endmodule
`default_nettype wire
